@@ sv/toic_pkg.sv @@
package toic_pkg;

    // fixed geometry of the converter
    localparam int DIM_SLOTS   = 6;
    localparam int WORD_W      = 32;
    localparam int DIM_W       = 16;
    localparam int RANK_W      = 3;
    localparam int DEF_MAX_RANK = 6;

    // configuration register indexes
    localparam logic [RANK_W-1:0] REG_RANK  = 3'd0;
    localparam logic [RANK_W-1:0] REG_DIM_0 = 3'd1;
    localparam logic [RANK_W-1:0] REG_DIM_5 = 3'd6;

    // command codes
    localparam logic CMD_TO_OFFSET = 1'b0;
    localparam logic CMD_TO_INDEX  = 1'b1;

    // payload of one division pipeline stage
    typedef struct packed {
        logic                                cmd;
        logic [WORD_W-1:0]                   off;
        logic [WORD_W-1:0]                   rem;
        logic [WORD_W-1:0]                   part;
        logic [WORD_W-1:0]                   nq;
        logic                                err;
        logic [DIM_SLOTS-1:0][WORD_W-1:0]    q;
    } toic_stage_t;

endpackage

@@ sv/tensor_offset_index_converter.sv @@
// Row-major tensor index/offset converter. Takes one request per clock while
// busy is low; each result appears on the result ports for one cycle marked by
// done, in request order. The receiver cannot stall. The division chain holds
// five 32-bit restoring dividers, one quotient bit per stage. After a write to
// the rank or a dimension register busy stays high while the strides are
// rebuilt with one shared 32x16 multiplier.
module tensor_offset_index_converter
    import toic_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [WORD_W-1:0]    offset_in,
    input  logic [DIM_W-1:0]     in_index_0,
    input  logic [DIM_W-1:0]     in_index_1,
    input  logic [DIM_W-1:0]     in_index_2,
    input  logic [DIM_W-1:0]     in_index_3,
    input  logic [DIM_W-1:0]     in_index_4,
    input  logic [DIM_W-1:0]     in_index_5,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RANK_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output logic                 done,
    output logic [WORD_W-1:0]    offset_out,
    output logic [WORD_W-1:0]    out_index_0,
    output logic [WORD_W-1:0]    out_index_1,
    output logic [WORD_W-1:0]    out_index_2,
    output logic [WORD_W-1:0]    out_index_3,
    output logic [WORD_W-1:0]    out_index_4,
    output logic [WORD_W-1:0]    out_index_5,
    output logic [WORD_W-1:0]    element_count,
    output logic                 div_error
);

    localparam int RANK_LIM = (MAX_RANK < DIM_SLOTS) ? MAX_RANK : DIM_SLOTS;
    localparam int NS       = WORD_W * (DIM_SLOTS - 1);

    // configuration and derived strides
    logic [RANK_W-1:0]                 rank_reg;
    logic [DIM_SLOTS-1:0][DIM_W-1:0]   dim_reg;
    logic [DIM_SLOTS-1:0][WORD_W-1:0]  stride_reg;
    logic [WORD_W-1:0]                 count_reg;
    logic [RANK_W-1:0]                 pos_reg;
    logic                              init_reg;
    logic                              run_reg;
    logic [WORD_W-1:0]                 sprod;
    logic [RANK_W-1:0]                 wr_rank;
    logic                              cfg_acc;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign busy      = init_reg || run_reg;
    assign sprod     = WORD_W'(stride_reg[pos_reg] * dim_reg[pos_reg]);
    assign wr_rank   = (cfg_data[RANK_W-1:0] > RANK_W'(RANK_LIM)) ?
                       RANK_W'(RANK_LIM) : cfg_data[RANK_W-1:0];

    // stride rebuild: innermost stride 1, then one multiply per cycle outward
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg   <= '0;
            for (int i = 0; i < DIM_SLOTS; i++)
            begin
                dim_reg[i]    <= DIM_W'(1);
                stride_reg[i] <= '0;
            end
            stride_reg[0] <= WORD_W'(1);
            count_reg  <= WORD_W'(1);
            pos_reg    <= '0;
            init_reg   <= 1'b0;
            run_reg    <= 1'b0;
        end
        else if (cfg_acc)
        begin
            if (cfg_index == REG_RANK)
            begin
                rank_reg <= wr_rank;
            end
            else if (cfg_index <= REG_DIM_5)
            begin
                dim_reg[cfg_index - REG_DIM_0] <= cfg_data[DIM_W-1:0];
            end
            if (cfg_index <= REG_DIM_5)
            begin
                init_reg <= 1'b1;
                run_reg  <= 1'b0;
            end
        end
        else if (init_reg)
        begin
            init_reg <= 1'b0;
            for (int i = 0; i < DIM_SLOTS; i++)
            begin
                stride_reg[i] <= '0;
            end
            if (rank_reg == '0)
            begin
                stride_reg[0] <= WORD_W'(1);
                count_reg     <= WORD_W'(1);
            end
            else
            begin
                stride_reg[rank_reg - 3'd1] <= WORD_W'(1);
                pos_reg <= rank_reg - 3'd1;
                run_reg <= 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (pos_reg == '0)
            begin
                count_reg <= sprod;
                run_reg   <= 1'b0;
            end
            else
            begin
                stride_reg[pos_reg - 3'd1] <= sprod;
                pos_reg <= pos_reg - 3'd1;
            end
        end
    end

    // front end: capture, products, pair sums, total
    logic                              acc;
    logic [2:0]                        fv_reg;
    logic [2:0]                        fcmd_reg;
    logic [2:0][WORD_W-1:0]            foff_reg;
    logic [DIM_SLOTS-1:0][DIM_W-1:0]   idx_reg;
    logic [DIM_SLOTS-1:0][WORD_W-1:0]  prod_reg;
    logic [2:0][WORD_W-1:0]            psum_reg;

    assign acc = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            fv_reg <= {fv_reg[1:0], acc};
        end
    end

    always_ff @(posedge clk)
    begin
        fcmd_reg[0] <= cmd;
        foff_reg[0] <= offset_in;
        // rank zero: stride 0 is 1, so drop index 0 to keep offset 0
        idx_reg[0]  <= (rank_reg == '0) ? '0 : in_index_0;
        idx_reg[1]  <= in_index_1;
        idx_reg[2]  <= in_index_2;
        idx_reg[3]  <= in_index_3;
        idx_reg[4]  <= in_index_4;
        idx_reg[5]  <= in_index_5;
        fcmd_reg[1] <= fcmd_reg[0];
        foff_reg[1] <= foff_reg[0];
        for (int i = 0; i < DIM_SLOTS; i++)
        begin
            prod_reg[i] <= WORD_W'(stride_reg[i] * idx_reg[i]);
        end
        fcmd_reg[2] <= fcmd_reg[1];
        foff_reg[2] <= foff_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            psum_reg[i] <= prod_reg[2*i] + prod_reg[2*i+1];
        end
    end

    // division chain: one quotient bit per stage
    logic [NS:0]        vld_reg;
    toic_stage_t        st_reg  [NS+1];
    toic_stage_t        st_next [NS+1];

    always_comb
    begin
        toic_stage_t        cur;
        toic_stage_t        nx;
        logic [WORD_W-1:0]  s;
        logic [WORD_W-1:0]  part_in;
        logic [WORD_W-1:0]  nq_in;
        logic [WORD_W:0]    shifted;
        logic               ge;
        nx          = '0;
        nx.cmd      = fcmd_reg[2];
        nx.rem      = foff_reg[2];
        nx.off      = psum_reg[0] + psum_reg[1] + psum_reg[2];
        st_next[0]  = nx;
        for (int t = 0; t < NS; t++)
        begin
            cur     = st_reg[t];
            s       = stride_reg[t / WORD_W];
            part_in = (t % WORD_W == 0) ? '0 : cur.part;
            nq_in   = (t % WORD_W == 0) ? cur.rem : cur.nq;
            shifted = {part_in, nq_in[WORD_W-1]};
            ge      = shifted >= {1'b0, s};
            nx      = cur;
            nx.part = ge ? WORD_W'(shifted - {1'b0, s}) : shifted[WORD_W-1:0];
            nx.nq   = {nq_in[WORD_W-2:0], ge};
            // last bit: commit quotient if this level is outside the innermost level in use
            if ((t % WORD_W == WORD_W - 1) && (cur.cmd == CMD_TO_INDEX) &&
                (int'(rank_reg) > t / WORD_W + 1))
            begin
                if (s == '0)
                begin
                    nx.err = 1'b1;
                end
                else
                begin
                    nx.q[t / WORD_W] = nx.nq;
                    nx.rem           = nx.part;
                end
            end
            st_next[t+1] = nx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-1:0], fv_reg[2]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t <= NS; t++)
        begin
            st_reg[t] <= st_next[t];
        end
    end

    // result register
    logic                              done_reg;
    logic [WORD_W-1:0]                 off_out_reg;
    logic [DIM_SLOTS-1:0][WORD_W-1:0]  oidx_reg;
    logic [DIM_SLOTS-1:0][WORD_W-1:0]  oidx_next;
    logic                              err_reg;

    always_comb
    begin
        for (int i = 0; i < DIM_SLOTS; i++)
        begin
            oidx_next[i] = '0;
            if (st_reg[NS].cmd == CMD_TO_INDEX)
            begin
                oidx_next[i] = st_reg[NS].q[i];
                if ((rank_reg != '0) && (i == int'(rank_reg) - 1))
                begin
                    oidx_next[i] = st_reg[NS].rem;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        off_out_reg <= (st_reg[NS].cmd == CMD_TO_OFFSET) ? st_reg[NS].off : '0;
        oidx_reg    <= oidx_next;
        err_reg     <= (st_reg[NS].cmd == CMD_TO_INDEX) && st_reg[NS].err;
    end

    assign done          = done_reg;
    assign offset_out    = off_out_reg;
    assign out_index_0   = oidx_reg[0];
    assign out_index_1   = oidx_reg[1];
    assign out_index_2   = oidx_reg[2];
    assign out_index_3   = oidx_reg[3];
    assign out_index_4   = oidx_reg[4];
    assign out_index_5   = oidx_reg[5];
    assign element_count = count_reg;
    assign div_error     = err_reg;

    // checks
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_acc && cfg_index <= REG_DIM_5) |=> busy)
        else $error("stride rebuild not started after config write");

    a_err_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_error) |-> (offset_out == '0))
        else $error("error flag on an offset result");

    a_rank0_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && rank_reg == '0) |-> (count_reg == WORD_W'(1)))
        else $error("element count not 1 at rank zero");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !fv_reg[0])
        else $error("request taken while busy");

endmodule

@@ sim/toic_checker.sv @@
`timescale 1ns / 1ps

// Watches the converter's config, request and result channels, keeps its own
// copy of the tensor shape, predicts each result and compares in order.
module toic_checker
    import toic_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           cmd,
    input  logic [WORD_W-1:0]              offset_in,
    input  logic [DIM_SLOTS-1:0][DIM_W-1:0] in_idx,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [RANK_W-1:0]              cfg_index,
    input  logic [WORD_W-1:0]              cfg_data,
    input  logic                           done,
    input  logic [WORD_W-1:0]              offset_out,
    input  logic [DIM_SLOTS-1:0][WORD_W-1:0] out_idx,
    input  logic [WORD_W-1:0]              element_count,
    input  logic                           div_error,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic [WORD_W-1:0]                offset;
        logic [DIM_SLOTS-1:0][WORD_W-1:0] coord;
        logic [WORD_W-1:0]                count;
        logic                             err;
    } conv_result_t;

    // shadow of the shape registers
    logic [RANK_W-1:0]             shape_rank;
    logic [DIM_SLOTS-1:0][DIM_W-1:0] shape_dims;
    conv_result_t                  conv_q[$];

    function automatic conv_result_t convert(logic c, logic [WORD_W-1:0] off,
                                             logic [DIM_SLOTS-1:0][DIM_W-1:0] ix);
        int                              r;
        logic [DIM_SLOTS-1:0][WORD_W-1:0] stride;
        logic [WORD_W-1:0]               rem;
        conv_result_t                    res;
        r = (shape_rank > DEF_MAX_RANK) ? DEF_MAX_RANK : int'(shape_rank);
        res = '0;
        stride = '0;
        // row-major strides, innermost in use is 1
        if (r == 0)
            stride[0] = WORD_W'(1);
        else
        begin
            stride[r-1] = WORD_W'(1);
            for (int i = r - 1; i > 0; i--)
                stride[i-1] = stride[i] * WORD_W'(shape_dims[i]);
        end
        res.count = WORD_W'(1);
        for (int i = 0; i < r; i++)
            res.count = res.count * WORD_W'(shape_dims[i]);
        if (c == CMD_TO_OFFSET)
        begin
            for (int i = 0; i < r; i++)
                res.offset = res.offset + stride[i] * WORD_W'(ix[i]);
        end
        else
        begin
            rem = off;
            if (r == 1)
                res.coord[0] = rem;
            else if (r >= 2)
            begin
                // outermost index keeps any excess; zero stride flags an error
                for (int i = 0; i + 1 < r; i++)
                begin
                    if (stride[i] == 0)
                        res.err = 1'b1;
                    else
                    begin
                        res.coord[i] = rem / stride[i];
                        rem = rem % stride[i];
                    end
                end
                res.coord[r-1] = rem;
            end
        end
        return res;
    endfunction

    task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        conv_result_t want;
        if (!rst_n)
        begin
            shape_rank <= '0;
            for (int i = 0; i < DIM_SLOTS; i++)
                shape_dims[i] <= DIM_W'(1);
        end
        else
        begin
            // config write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RANK)
                    shape_rank <= cfg_data[RANK_W-1:0];
                else if (cfg_index >= REG_DIM_0 && cfg_index <= REG_DIM_5)
                    shape_dims[cfg_index - REG_DIM_0] <= cfg_data[DIM_W-1:0];
            end
            // accepted request
            if (start && !busy)
                conv_q.push_back(convert(cmd, offset_in, in_idx));
            // result
            if (done)
            begin
                if (conv_q.size() == 0)
                begin
                    $display("%0t unexpected result", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = conv_q.pop_front();
                    if (offset_out !== want.offset)
                        report("offset_out", offset_out, want.offset);
                    for (int i = 0; i < DIM_SLOTS; i++)
                        if (out_idx[i] !== want.coord[i])
                            report($sformatf("out_index_%0d", i), out_idx[i], want.coord[i]);
                    if (element_count !== want.count)
                        report("element_count", element_count, want.count);
                    if (div_error !== want.err)
                        report("div_error", WORD_W'(div_error), WORD_W'(want.err));
                end
            end
            // queue already reflects this edge's request and result
            pending <= conv_q.size();
        end
    end

endmodule

@@ sim/tensor_offset_index_converter_tb.sv @@
`timescale 1ns / 1ps

module tensor_offset_index_converter_tb;
    import toic_pkg::*;

    localparam int DRAIN_CYCLES = 200;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic                             cmd = CMD_TO_OFFSET;
    logic [WORD_W-1:0]                offset_in = '0;
    logic [DIM_SLOTS-1:0][DIM_W-1:0]  in_idx = '0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [RANK_W-1:0]                cfg_index = REG_RANK;
    logic [WORD_W-1:0]                cfg_data = '0;
    logic                             done;
    logic [WORD_W-1:0]                offset_out;
    logic [DIM_SLOTS-1:0][WORD_W-1:0] out_idx;
    logic [WORD_W-1:0]                element_count;
    logic                             div_error;
    int                               fail_count;
    int                               pending;
    bit                               allow_idle = 1'b1;
    logic [DIM_W-1:0]                 cur_dims[DIM_SLOTS];
    int                               cur_rank;

    always #4 clk = ~clk;

    tensor_offset_index_converter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .offset_in(offset_in),
        .in_index_0(in_idx[0]), .in_index_1(in_idx[1]), .in_index_2(in_idx[2]),
        .in_index_3(in_idx[3]), .in_index_4(in_idx[4]), .in_index_5(in_idx[5]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .offset_out(offset_out),
        .out_index_0(out_idx[0]), .out_index_1(out_idx[1]), .out_index_2(out_idx[2]),
        .out_index_3(out_idx[3]), .out_index_4(out_idx[4]), .out_index_5(out_idx[5]),
        .element_count(element_count), .div_error(div_error)
    );

    toic_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .offset_in(offset_in), .in_idx(in_idx), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .offset_out(offset_out), .out_idx(out_idx),
        .element_count(element_count), .div_error(div_error),
        .fail_count(fail_count), .pending(pending)
    );

    // block until all results are back, then let the pipe go quiet
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one register write; caller has drained the pipe
    task automatic write_reg(logic [RANK_W-1:0] idx, logic [WORD_W-1:0] data);
        bit rdy;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            rdy = cfg_ready;
            @(posedge clk);
            if (rdy)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_RANK)
            cur_rank = (data[RANK_W-1:0] > DEF_MAX_RANK) ? DEF_MAX_RANK : data[RANK_W-1:0];
        else if (idx >= REG_DIM_0 && idx <= REG_DIM_5)
            cur_dims[idx - REG_DIM_0] = data[DIM_W-1:0];
    endtask

    task automatic set_shape(int rank, logic [DIM_W-1:0] d0, logic [DIM_W-1:0] d1,
                             logic [DIM_W-1:0] d2, logic [DIM_W-1:0] d3,
                             logic [DIM_W-1:0] d4, logic [DIM_W-1:0] d5);
        drain();
        write_reg(REG_RANK, WORD_W'(rank) | ($urandom & 32'hFFFF_FFF8));
        write_reg(REG_DIM_0, {DIM_W'($urandom_range(0, 65535)), d0});
        write_reg(RANK_W'(REG_DIM_0 + 1), {DIM_W'($urandom_range(0, 65535)), d1});
        write_reg(RANK_W'(REG_DIM_0 + 2), {DIM_W'($urandom_range(0, 65535)), d2});
        write_reg(RANK_W'(REG_DIM_0 + 3), {DIM_W'($urandom_range(0, 65535)), d3});
        write_reg(RANK_W'(REG_DIM_0 + 4), {DIM_W'($urandom_range(0, 65535)), d4});
        write_reg(REG_DIM_5, {DIM_W'($urandom_range(0, 65535)), d5});
    endtask

    // issue one request; start stays high across back-to-back requests
    task automatic send(logic c, logic [WORD_W-1:0] off, logic [DIM_SLOTS-1:0][DIM_W-1:0] ix);
        bit b;
        @(negedge clk);
        if (allow_idle && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        offset_in <= off;
        in_idx    <= ix;
        forever
        begin
            b = busy;
            @(posedge clk);
            if (!b)
                break;
            @(negedge clk);
        end
    endtask

    // random request, mostly in range of the current shape
    task automatic send_random();
        logic [DIM_SLOTS-1:0][DIM_W-1:0] ix;
        logic [WORD_W-1:0]               off;
        logic [WORD_W-1:0]               n;
        n = WORD_W'(1);
        for (int i = 0; i < DIM_SLOTS; i++)
        begin
            if (i < cur_rank)
                n = n * WORD_W'(cur_dims[i]);
            if ($urandom_range(0, 3) == 0 || cur_dims[i] == 0)
                ix[i] = DIM_W'($urandom);
            else
                ix[i] = DIM_W'($urandom_range(0, cur_dims[i] - 1));
        end
        if ($urandom_range(0, 3) == 0 || n == 0)
            off = $urandom;
        else
            off = $urandom_range(0, n - 1);
        send(1'($urandom_range(0, 1)), off, ix);
    endtask

    logic [DIM_SLOTS-1:0][DIM_W-1:0] all_ones;
    logic [DIM_SLOTS-1:0][DIM_W-1:0] ramp;

    initial
    begin
        cur_rank = 0;
        for (int i = 0; i < DIM_SLOTS; i++)
            cur_dims[i] = DIM_W'(1);
        all_ones = '1;
        ramp = {16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // rank zero after reset
        send(CMD_TO_OFFSET, '0, all_ones);
        send(CMD_TO_INDEX, 32'hFFFF_FFFF, all_ones);

        // rank one: offset passes straight through
        set_shape(1, 16'd7, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3);
        send(CMD_TO_INDEX, 32'hDEAD_BEEF, '0);
        send(CMD_TO_OFFSET, '0, all_ones);

        // full rank, largest dims, wrapping products
        set_shape(6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(CMD_TO_OFFSET, '0, all_ones);
        send(CMD_TO_OFFSET, '0, '0);
        send(CMD_TO_INDEX, 32'hFFFF_FFFF, '0);
        send(CMD_TO_INDEX, 32'h0000_0000, '0);

        // zero dimension gives a zero stride
        set_shape(4, 16'd5, 16'd0, 16'd3, 16'd4, 16'd9, 16'd9);
        send(CMD_TO_INDEX, 32'd1234, '0);
        send(CMD_TO_OFFSET, '0, ramp);
        send(CMD_TO_INDEX, 32'hFFFF_FFFF, '0);

        // rank field of 7 saturates; register index 7 is ignored
        set_shape(7, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send(CMD_TO_INDEX, 32'd5039, '0);
        send(CMD_TO_INDEX, 32'd5040, '0);
        send(CMD_TO_OFFSET, '0, ramp);

        // indices beyond rank are ignored, out-of-range coordinate
        set_shape(3, 16'd4, 16'd8, 16'd2, 16'd1, 16'd1, 16'd1);
        send(CMD_TO_OFFSET, '0, all_ones);
        send(CMD_TO_INDEX, 32'd200, '0);
        send(CMD_TO_OFFSET, '0, ramp);

        // random phases over a spread of shapes
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [DIM_W-1:0] d[DIM_SLOTS];
            for (int i = 0; i < DIM_SLOTS; i++)
            begin
                case ($urandom_range(0, 9))
                    0: d[i] = '0;
                    1: d[i] = 16'hFFFF;
                    2: d[i] = DIM_W'($urandom);
                    default: d[i] = DIM_W'($urandom_range(1, 12));
                endcase
            end
            set_shape(ph == 0 ? 6 : $urandom_range(0, 7), d[0], d[1], d[2], d[3], d[4], d[5]);
            // one phase runs back to back
            allow_idle = (ph != 3);
            for (int k = 0; k < 250; k++)
                send_random();
        end
        allow_idle = 1'b1;
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
